>>> src/qph_pkg.sv
// Shared widths, command codes and the memory request type of the
// quadratic probe hash insert unit. No dependencies.
package qph_pkg;

	localparam int KEY_W     = 31;
	localparam int SIZE_W    = 17;
	localparam int POS_W     = 16;
	localparam int POS_LIMIT = 65536;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// One access to the occupancy memory per cycle; addr is cut down to the
	// memory's own address width inside the memory.
	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [POS_W-1:0] addr;
		logic             wdata;
	} mem_req_t;

endpackage

>>> src/qph_chan_if.sv
// Valid/ready channels of the hash insert unit: request items in, results out.
// Depends on qph_pkg.
interface qph_req_if;
	import qph_pkg::*;

	logic             valid;
	logic             ready;
	logic             command;
	logic [KEY_W-1:0] key;

	modport source (output valid, command, key, input ready);
	modport sink   (input valid, command, key, output ready);
endinterface

interface qph_res_if;
	import qph_pkg::*;

	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic             placed;

	modport source (output valid, position, placed, input ready);
	modport sink   (input valid, position, placed, output ready);
endinterface

>>> src/quadratic_probe_hash_insert_unit.sv
// Top level of the quadratic probe hash insert unit: control sequencer,
// size register and result register. Depends on qph_pkg, qph_chan_if,
// qph_mod_unit and qph_occ_mem.
//
//  channel   dir  fields              transfer
//  request   in   command, key        valid & ready
//  result    out  position, placed    valid & ready
//  cfg       in   cfg_wdata           cfg_wen (table_size)
//
// Insert: the request is taken, the remainder unit gives the home slot, each
// probe is a memory read, then a check/write, and the result register is
// loaded last; the number of probes is bounded by the table size.
// Clear: one memory entry zeroed per cycle over all min(MAX_SLOTS, 65536)
// entries, then the result. After reset the same pass runs with no result;
// requests wait until it ends. A stalled result holds only the finishing
// item; the next request is taken as soon as the sequencer is idle.
module quadratic_probe_hash_insert_unit #(
	parameter int MAX_SLOTS = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [qph_pkg::SIZE_W-1:0] cfg_wdata,
	qph_req_if.sink                    request,
	qph_res_if.source                  result
);
	import qph_pkg::*;

	localparam int DEPTH = (MAX_SLOTS < POS_LIMIT) ? MAX_SLOTS : POS_LIMIT;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]        state_q;
	logic [SIZE_W-1:0] size_q;
	logic              clr_res_q;
	logic [AW-1:0]     clr_addr_q;
	logic [POS_W-1:0]  slot_q;
	logic [POS_W-1:0]  inc_q;
	logic [POS_W-1:0]  d_q;
	logic [POS_W-1:0]  fin_pos_q;
	logic              fin_placed_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_placed_q;

	logic              accept;
	logic              div_start;
	logic              div_done;
	logic [SIZE_W-1:0] div_rem;
	mem_req_t          mem_req;
	logic              mem_rdata;
	logic [SIZE_W-1:0] slot_sum;
	logic [SIZE_W-1:0] inc_sum;
	logic [POS_W-1:0]  slot_next;
	logic [POS_W-1:0]  inc_next;
	logic              more_probes;
	logic              out_free;

	assign accept    = request.valid && request.ready;
	assign div_start = accept && (request.command == CMD_INSERT);
	assign out_free  = !out_valid_q || result.ready;

	// Next probe: slot += 2d+1 and the odd step += 2, both kept below size.
	assign slot_sum  = {1'b0, slot_q} + {1'b0, inc_q};
	assign inc_sum   = {1'b0, inc_q} + SIZE_W'(2);
	assign slot_next = (slot_sum >= size_q) ? POS_W'(slot_sum - size_q) : slot_sum[POS_W-1:0];
	assign inc_next  = (inc_sum >= size_q) ? POS_W'(inc_sum - size_q) : inc_sum[POS_W-1:0];
	assign more_probes = ({1'b0, d_q} + SIZE_W'(1)) < size_q;

	qph_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (request.key),
		.divisor   (size_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	qph_occ_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_CLR: begin
				mem_req.wr_en = 1'b1;
				mem_req.addr  = POS_W'(clr_addr_q);
				mem_req.wdata = 1'b0;
			end
			ST_RD: begin
				mem_req.rd_en = 1'b1;
				mem_req.addr  = slot_q;
			end
			ST_CHK: begin
				mem_req.wr_en = !mem_rdata;
				mem_req.addr  = slot_q;
				mem_req.wdata = 1'b1;
			end
			default: mem_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			size_q      <= SIZE_W'(2);
			clr_res_q   <= 1'b0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				if (cfg_wdata > SIZE_W'(DEPTH))
					size_q <= SIZE_W'(DEPTH);
				else if (cfg_wdata < SIZE_W'(2))
					size_q <= SIZE_W'(2);
				else
					size_q <= cfg_wdata;
			end

			if (out_valid_q && result.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (request.command == CMD_CLEAR) begin
							clr_res_q  <= 1'b1;
							clr_addr_q <= '0;
							state_q    <= ST_CLR;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DEPTH - 1))
						state_q <= clr_res_q ? ST_DONE : ST_IDLE;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_CHK;
				ST_CHK: begin
					if (!mem_rdata || !more_probes)
						state_q <= ST_DONE;
					else
						state_q <= ST_RD;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_CLR: begin
				fin_pos_q    <= '0;
				fin_placed_q <= 1'b0;
			end
			ST_DIV: begin
				slot_q <= div_rem[POS_W-1:0];
				inc_q  <= POS_W'(1);
				d_q    <= '0;
			end
			ST_CHK: begin
				if (!mem_rdata) begin
					fin_pos_q    <= slot_q;
					fin_placed_q <= 1'b1;
				end else if (more_probes) begin
					slot_q <= slot_next;
					inc_q  <= inc_next;
					d_q    <= d_q + 1'b1;
				end else begin
					fin_pos_q    <= '0;
					fin_placed_q <= 1'b0;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_pos_q    <= fin_pos_q;
					out_placed_q <= fin_placed_q;
				end
			end
			default: ;
		endcase
	end

	assign request.ready   = (state_q == ST_IDLE);
	assign result.valid    = out_valid_q;
	assign result.position = out_pos_q;
	assign result.placed   = out_placed_q;

endmodule

>>> src/qph_mod_unit.sv
// Iterative remainder unit: key mod table size, two restoring steps a cycle.
// Depends on qph_pkg.
module qph_mod_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [qph_pkg::KEY_W-1:0]  dividend,
	input  logic [qph_pkg::SIZE_W-1:0] divisor,
	output logic                      done,
	output logic [qph_pkg::SIZE_W-1:0] remainder
);
	import qph_pkg::*;

	localparam int DVD_W   = KEY_W + 1;
	localparam int STEPS   = DVD_W / 2;
	localparam int CNT_W   = $clog2(STEPS);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] div_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W-1:0] rem_n;

	always_comb begin
		rem_n = rem_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, dvd_q[DVD_W-1-i]};
			if (trial >= {1'b0, div_q})
				rem_n = SIZE_W'(trial - {1'b0, div_q});
			else
				rem_n = trial[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {1'b0, dividend};
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-3:0], 2'b00};
			rem_q <= rem_n;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

>>> src/qph_occ_mem.sv
// Occupancy store: one bit per slot, one access a cycle, registered read data.
// Depends on qph_pkg.
module qph_occ_mem #(
	parameter int DEPTH = 65536
) (
	input  logic              clk,
	input  qph_pkg::mem_req_t req,
	output logic              rdata
);
	import qph_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.addr[AW-1:0]] <= req.wdata;
		if (req.rd_en)
			rdata <= mem[req.addr[AW-1:0]];
	end

endmodule

>>> test/quadratic_probe_hash_insert_unit_tb.sv
// Self-checking testbench for quadratic_probe_hash_insert_unit: directed and random
// insert/clear traffic over many table sizes, checked against an occupancy predictor.
// Depends on qph_pkg, qph_chan_if and the unit's RTL.
module quadratic_probe_hash_insert_unit_tb;
	import qph_pkg::*;

	localparam int SLOTS        = 65536;
	localparam int SLOT_CAP     = (SLOTS < POS_LIMIT) ? SLOTS : POS_LIMIT;
	localparam int QUIET_LIMIT  = 600000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic             command;
		logic [KEY_W-1:0] key;
	} req_item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             placed;
	} placement_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_wen   = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_cmd   = CMD_INSERT;
	logic [KEY_W-1:0]  req_key   = '0;
	logic              res_ready = 1'b0;
	logic              no_idle       = 1'b0;
	logic              long_hold_req = 1'b0;

	qph_req_if req_ch ();
	qph_res_if res_ch ();

	assign req_ch.valid   = req_valid;
	assign req_ch.command = req_cmd;
	assign req_ch.key     = req_key;
	assign res_ch.ready   = res_ready;

	quadratic_probe_hash_insert_unit #(.MAX_SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.request(req_ch),
		.result(res_ch)
	);

	req_item_t         request_q [$];
	placement_t        placement_q [$];
	req_item_t         next_item;
	placement_t        want;
	logic [SIZE_W-1:0] size_reg = SIZE_W'(2);
	bit [SLOT_CAP-1:0] occupied = '0;
	int errors      = 0;
	int outstanding = 0;
	int n_insert    = 0;
	int n_placed    = 0;
	int n_clear     = 0;
	int n_sizes     = 0;
	int send_gap    = 0;
	int stall_gap   = 0;
	int hold_left   = 0;
	int quiet       = 0;
	bit long_hold_taken = 1'b0;

	always #4 clk = ~clk;

	function automatic int unsigned table_slots();
		int unsigned s;
		s = size_reg;
		if (s > SLOT_CAP)
			s = SLOT_CAP;
		if (s < 2)
			s = 2;
		return s;
	endfunction

	// d = 0 is the home slot itself
	function automatic placement_t place_key(input logic cmd, input logic [KEY_W-1:0] k);
		placement_t r;
		longint unsigned s, home, slot, d;
		r = '0;
		if (cmd == CMD_CLEAR) begin
			occupied = '0;
			return r;
		end
		s = table_slots();
		home = longint'(k) % s;
		for (d = 0; d < s; d++) begin
			slot = (home + d * d) % s;
			if (!occupied[slot]) begin
				occupied[slot] = 1'b1;
				r.position = slot[POS_W-1:0];
				r.placed = 1'b1;
				return r;
			end
		end
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_cmd <= CMD_INSERT;
			req_key <= '0;
			send_gap = 0;
		end else begin
			if (req_valid && req_ch.ready) begin
				placement_q.push_back(place_key(req_cmd, req_key));
				if (req_cmd == CMD_CLEAR)
					n_clear++;
				else
					n_insert++;
				if (!no_idle && $urandom_range(0, 4) == 0)
					send_gap = $urandom_range(1, 4);
			end
			if (!req_valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (request_q.size() == 0) begin
					req_valid <= 1'b0;
				end else begin
					next_item = request_q.pop_front();
					req_valid <= 1'b1;
					req_cmd <= next_item.command;
					req_key <= next_item.key;
				end
			end
		end
	end

	// result monitor and ready control
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_gap = 0;
			hold_left = 0;
			long_hold_taken = 1'b0;
		end else begin
			if (res_ch.valid && res_ready) begin
				outstanding--;
				if (res_ch.placed === 1'b1)
					n_placed++;
				if (placement_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: position %0d placed %0b",
						$time, res_ch.position, res_ch.placed);
				end else begin
					want = placement_q.pop_front();
					if (res_ch.position !== want.position) begin
						errors++;
						$display("%0t: position mismatch: expected %0d, actual %0d",
							$time, want.position, res_ch.position);
					end
					if (res_ch.placed !== want.placed) begin
						errors++;
						$display("%0t: placed mismatch: expected %0b, actual %0b",
							$time, want.placed, res_ch.placed);
					end
				end
			end
			if (long_hold_req && !long_hold_taken) begin
				long_hold_taken = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (stall_gap > 0) begin
				stall_gap--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 5) == 0)
					stall_gap = $urandom_range(1, 4);
			end
		end
	end

	// quiet-cycle watchdog; a probe run over a full table is the longest legal stretch
	always @(posedge clk) begin
		if ((req_valid && req_ch.ready) || (res_ch.valid && res_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet);
			$display("quadratic_probe_hash_insert_unit_tb: errors");
			$finish;
		end
	end

	task automatic queue_item(input logic cmd, input logic [KEY_W-1:0] k);
		req_item_t it;
		it.command = cmd;
		it.key = k;
		request_q.push_back(it);
		outstanding++;
	endtask

	task automatic wait_idle();
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_size(input logic [SIZE_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		size_reg = v;
		n_sizes++;
	endtask

	// a quarter of the keys land on a few home slots to force long probe runs
	task automatic run_phase(input logic [SIZE_W-1:0] v, input int n, input bit clear_first);
		int unsigned s;
		logic [KEY_W-1:0] k;
		set_size(v);
		s = table_slots();
		if (clear_first)
			queue_item(CMD_CLEAR, KEY_W'($urandom));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				k = KEY_W'(($urandom & 32'h7fff) * s + $urandom_range(0, 2));
			else
				k = KEY_W'($urandom);
			queue_item(CMD_INSERT, k);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// two-slot table from reset: fill it, then a miss, then clear
		queue_item(CMD_INSERT, 31'd0);
		queue_item(CMD_INSERT, 31'd1);
		queue_item(CMD_INSERT, 31'h7fffffff);
		queue_item(CMD_CLEAR, 31'h7fffffff);
		queue_item(CMD_INSERT, 31'd5);
		// sizes below two saturate to two
		set_size(17'd0);
		queue_item(CMD_INSERT, 31'd3);
		queue_item(CMD_INSERT, 31'd6);
		set_size(17'd1);
		queue_item(CMD_INSERT, 31'd8);
		// grow without clear: low slots stay taken
		set_size(17'h1ffff);
		queue_item(CMD_INSERT, 31'd0);
		queue_item(CMD_INSERT, 31'd65536);
		queue_item(CMD_INSERT, 31'h7fffffff);
		queue_item(CMD_INSERT, 31'd65535);
		queue_item(CMD_INSERT, 31'd2);
		set_size(17'd65536);
		queue_item(CMD_INSERT, 31'd1);
		set_size(17'd65537);
		queue_item(CMD_INSERT, 31'd131072);
		// shrink onto leftover entries: every probe hits a used slot
		set_size(17'd3);
		queue_item(CMD_INSERT, 31'd0);
		queue_item(CMD_INSERT, 31'd2);
		queue_item(CMD_CLEAR, 31'd0);

		run_phase(17'd7, 40, 1'b1);
		run_phase(17'd13, 40, 1'b0);
		run_phase(17'd0, 20, 1'b0);
		wait_idle();
		long_hold_req <= 1'b1;
		run_phase(17'd31, 50, 1'b0);
		run_phase(17'd101, 50, 1'b0);
		run_phase(SIZE_W'($urandom_range(2, 400)), 40, 1'b0);
		run_phase(17'd997, 60, 1'b1);
		run_phase(17'd65521, 60, 1'b0);
		run_phase(17'd1, 20, 1'b0);
		run_phase(17'd100000, 60, 1'b1);
		run_phase(17'd3, 20, 1'b0);
		wait_idle();
		no_idle <= 1'b1;
		run_phase(17'd5, 40, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (placement_q.size() != 0) begin
			errors += placement_q.size();
			$display("%0t: %0d results never arrived", $time, placement_q.size());
		end
		$display("run covered %0d inserts (%0d placed, %0d refused) and %0d clears",
			n_insert, n_placed, n_insert - n_placed, n_clear);
		$display("over %0d size writes, saturated sizes and both size extremes among them",
			n_sizes);
		if (errors == 0)
			$display("quadratic_probe_hash_insert_unit_tb: clean");
		else
			$display("quadratic_probe_hash_insert_unit_tb: errors");
		$finish;
	end

endmodule
